>>> design/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the sorted table search unit
// Table geometry, request codes and the beat formats of both channels.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 7;

    // Request codes; the unused code answers with an all-zero result
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_SEARCH = 2'd2
    } req_t;

    // Input beat
    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } in_t;

    // Result beat
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             status;
    } out_t;

endpackage

>>> design/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage and registered read, no reset on the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl: request sequencer for the sorted table
// Runs clear, ordered insert (shift-up walk) and binary search against the
// table RAM, and presents one result per request.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  stbs_pkg::in_t                 req,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output stbs_pkg::out_t                res,
    // table RAM
    output logic                          wr_en,
    output logic [stbs_pkg::ADDR_W-1:0]   wr_addr,
    output logic [stbs_pkg::DATA_W-1:0]   wr_data,
    output logic                          rd_en,
    output logic [stbs_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [stbs_pkg::DATA_W-1:0]   rd_data
);

    import stbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RUN,
        ST_INS_LAST,
        ST_SRCH_PROBE,
        ST_SRCH_CMP,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    out_t                     res_reg, res_next;

    logic signed [DATA_W-1:0] entry;
    logic [CNT_W:0]           mid_sum;

    assign entry   = $signed(rd_data);
    // floor((lo + hi_incl) / 2) with hi kept exclusive
    assign mid_sum = ({1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1)) >> 1;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Next-state and RAM control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        key_next   = key_reg;
        ptr_next   = ptr_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg + ADDR_W'(1);
        wr_data    = key_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next   = '0;
                    key_next   = req.value;
                    state_next = ST_DONE;
                    unique case (req.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_INSERT:
                        begin
                            priority if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty table: value goes straight to entry 0
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = req.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // walk down from the top entry
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                                ptr_next   = ADDR_W'(count_reg - CNT_W'(1));
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_INS_RUN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = ST_SRCH_PROBE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // rd_data holds entry[ptr]; larger entries move up one slot
            ST_INS_RUN:
            begin
                wr_en = 1'b1;
                if (entry > key_reg)
                begin
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg - ADDR_W'(1);
                        ptr_next   = ptr_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    // equal or smaller: new value lands just above it
                    state_next = ST_DONE;
                end
            end

            // every entry was larger: value goes to the bottom
            ST_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                state_next = ST_DONE;
            end

            // issue the probe read, or finish on an empty range
            ST_SRCH_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(mid_sum);
                    mid_next   = ADDR_W'(mid_sum);
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // compare the probed entry and halve the range
            ST_SRCH_CMP:
            begin
                priority if (entry == key_reg)
                begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(mid_reg);
                    state_next        = ST_DONE;
                end
                else if (entry < key_reg)
                begin
                    lo_next    = CNT_W'(mid_reg) + CNT_W'(1);
                    state_next = ST_SRCH_PROBE;
                end
                else
                begin
                    hi_next    = CNT_W'(mid_reg);
                    state_next = ST_SRCH_PROBE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ptr_reg <= ptr_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
    end

endmodule

>>> design/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit: sorted table with binary search
// Top level: request sequencer, table RAM and the result output register.
// ----------------------------------------------------------------------------
// The unit keeps up to TABLE_DEPTH (128) signed 32-bit values in ascending
// order in one RAM and answers one result beat per request beat. It works
// on one request at a time, paced by the single RAM read port and its
// registered read. An insert walks down from the top entry, moving one
// larger entry up per cycle. A search makes at most log2(count)+1 probes.
// A finished result sits in the output register, so the next request is
// taken while it waits to be read.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  stbs_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output stbs_pkg::out_t out_data
);

    import stbs_pkg::*;

    logic              res_valid;
    logic              res_ready;
    out_t              res;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              out_valid_reg;
    out_t              out_data_reg;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: loads when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker: port-level checks for the sorted table search unit
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input stbs_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input stbs_pkg::out_t out_data
);

    import stbs_pkg::*;

    // A stalled result beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // One request at a time: no second beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    // A miss or a non-search request reports position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.position == '0)
        else $error("nonzero position without a match");

    // A hit and a dropped insert never come together
    a_hit_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.found && out_data.status))
        else $error("found and status both set");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (.*);
